### rtl/core/gmf_pkg.sv
package gmf_pkg;

   localparam int PIX_W          = 8;
   localparam int WIN_SIZE       = 9;
   localparam int CFG_WIDTH_W    = 11;
   localparam int CFG_HEIGHT_W   = 12;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 12;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int FIFO_DEPTH     = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Gray weights as unsigned Q0.8 fractions.
   localparam logic [PIX_W-1:0] GRAY_RED   = 8'd77;
   localparam logic [PIX_W-1:0] GRAY_GREEN = 8'd151;
   localparam logic [PIX_W-1:0] GRAY_BLUE  = 8'd28;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN_SIZE-1:0] win_type;

   typedef struct packed {
      logic result;
      logic last;
      logic border;
   } gmf_tag_type;

   typedef struct packed {
      pix_type gray_value;
      pix_type filtered_value;
      logic    last_of_frame;
   } gmf_result_type;

endpackage

### rtl/core/gmf_req_if.sv
interface gmf_req_if;
   import gmf_pkg::*;

   logic    valid;
   logic    ready;
   logic    opcode;
   pix_type red;
   pix_type green;
   pix_type blue;

   modport source (output valid, output opcode, output red, output green, output blue,
                   input ready);
   modport sink (input valid, input opcode, input red, input green, input blue,
                 output ready);
endinterface

### rtl/core/gmf_rsp_if.sv
interface gmf_rsp_if;
   import gmf_pkg::*;

   logic    valid;
   logic    ready;
   pix_type gray_value;
   pix_type filtered_value;
   logic    last_of_frame;

   modport source (output valid, output gray_value, output filtered_value,
                   output last_of_frame, input ready);
   modport sink (input valid, input gray_value, input filtered_value,
                 input last_of_frame, output ready);
endinterface

### rtl/core/gmf_line_store.sv
module gmf_line_store #(
   parameter int MAX_WIDTH = gmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  logic [$clog2(MAX_WIDTH)-1:0] push_addr,
   input  gmf_pkg::pix_type             push_gray,
   input  gmf_pkg::gmf_tag_type         push_tag,
   output logic                         win_valid,
   output gmf_pkg::win_type             win,
   output gmf_pkg::gmf_tag_type         win_tag
);
   import gmf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   pix_type upper_mem [MAX_WIDTH];
   pix_type middle_mem [MAX_WIDTH];

   pix_type     up_rd_ff, mid_rd_ff;
   logic        s1_valid_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pix_type     s1_gray_ff;
   gmf_tag_type s1_tag_ff;
   logic        s1_fwd_ff;
   pix_type     fwd_up_ff, fwd_mid_ff;
   pix_type     up_val, mid_val;
   win_type     win_ff;
   logic        win_valid_ff;
   gmf_tag_type win_tag_ff;

   // A read that meets the write of the previous item at the same column
   // (single-column frames) takes the written values instead of the stale word.
   assign up_val  = s1_fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_val = s1_fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         up_rd_ff <= upper_mem[push_addr];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_addr_ff] <= mid_val;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mid_rd_ff <= middle_mem[push_addr];
      end
      if (s1_valid_ff) begin
         middle_mem[s1_addr_ff] <= s1_gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= push_valid;
         win_valid_ff <= s1_valid_ff && s1_tag_ff.result;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= push_addr;
      s1_gray_ff <= push_gray;
      s1_tag_ff  <= push_tag;
      s1_fwd_ff  <= push_valid && s1_valid_ff && (s1_addr_ff == push_addr);
      win_tag_ff <= s1_tag_ff;
      if (s1_valid_ff) begin
         fwd_up_ff  <= mid_val;
         fwd_mid_ff <= s1_gray_ff;
         win_ff[0]  <= win_ff[1];
         win_ff[1]  <= win_ff[2];
         win_ff[2]  <= up_val;
         win_ff[3]  <= win_ff[4];
         win_ff[4]  <= win_ff[5];
         win_ff[5]  <= mid_val;
         win_ff[6]  <= win_ff[7];
         win_ff[7]  <= win_ff[8];
         win_ff[8]  <= s1_gray_ff;
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign win_tag   = win_tag_ff;

endmodule

### rtl/core/gmf_median.sv
module gmf_median (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  gmf_pkg::win_type       in_win,
   input  gmf_pkg::gmf_tag_type   in_tag,
   output logic                   out_valid,
   output gmf_pkg::gmf_result_type out_res
);
   import gmf_pkg::*;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Stage one: each row sorted into low, middle and high.
   pix_type     lo_ff [3];
   pix_type     md_ff [3];
   pix_type     hi_ff [3];
   logic        m1_valid_ff;
   pix_type     m1_centre_ff;
   gmf_tag_type m1_tag_ff;

   // Stage two: the median is the middle of these three.
   pix_type     max_lo_ff, med_md_ff, min_hi_ff;
   logic        m2_valid_ff;
   pix_type     m2_centre_ff;
   gmf_tag_type m2_tag_ff;

   logic           out_valid_ff;
   gmf_result_type out_res_ff;
   pix_type        median;

   assign median = med3(max_lo_ff, med_md_ff, min_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff  <= in_valid;
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff[0] <= min2(min2(in_win[0], in_win[1]), in_win[2]);
      md_ff[0] <= med3(in_win[0], in_win[1], in_win[2]);
      hi_ff[0] <= max2(max2(in_win[0], in_win[1]), in_win[2]);
      lo_ff[1] <= min2(min2(in_win[3], in_win[4]), in_win[5]);
      md_ff[1] <= med3(in_win[3], in_win[4], in_win[5]);
      hi_ff[1] <= max2(max2(in_win[3], in_win[4]), in_win[5]);
      lo_ff[2] <= min2(min2(in_win[6], in_win[7]), in_win[8]);
      md_ff[2] <= med3(in_win[6], in_win[7], in_win[8]);
      hi_ff[2] <= max2(max2(in_win[6], in_win[7]), in_win[8]);
      m1_centre_ff <= in_win[4];
      m1_tag_ff    <= in_tag;

      max_lo_ff    <= max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
      med_md_ff    <= med3(md_ff[0], md_ff[1], md_ff[2]);
      min_hi_ff    <= min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
      m2_centre_ff <= m1_centre_ff;
      m2_tag_ff    <= m1_tag_ff;

      out_res_ff.gray_value     <= m2_centre_ff;
      out_res_ff.filtered_value <= m2_tag_ff.border ? m2_centre_ff : median;
      out_res_ff.last_of_frame  <= m2_tag_ff.last;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

### rtl/core/gmf_out_fifo.sv
module gmf_out_fifo #(
   parameter int DEPTH = gmf_pkg::FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  gmf_pkg::gmf_result_type wr_data,
   output logic                    rd_valid,
   output gmf_pkg::gmf_result_type rd_data,
   input  logic                    rd_ready
);
   import gmf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gmf_result_type   mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rd_take;

   assign rd_valid = (count_ff != '0);
   assign rd_take  = rd_valid && rd_ready;
   assign rd_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/gray_median_3x3_filter.sv
// Streaming 3x3 median filter on gray-converted RGB pixels in raster order. The block
// takes one item per clock while it is not stalled: each pixel is converted to gray,
// written to two line stores (one read and one write of each store per item), and a
// 3x3 window feeds a three-stage sorting pipeline. The result for a pixel is released
// when the item image_width+1 places later is taken; drain items push empty slots to
// flush the end of the frame, and pixel items sent after the last pixel of the frame
// act as drains. Border pixels return their own gray level as the filtered value. The
// releasing item passes the line store and the sorting stages; its result enters an
// output queue of eight entries; the input stalls once eight results are outstanding
// in the pipeline and the queue together, so the queue never overflows. After reset
// and after every configuration write the input is held off while the frame size is
// recomputed. Configuration is written between frames. The line stores are not
// cleared: every neighborhood used for a median lies inside the current frame.
module gray_median_3x3_filter #(
   parameter int MAX_WIDTH = gmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   gmf_req_if.sink                          req_chan,
   gmf_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [gmf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gmf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gmf_pkg::*;

   localparam int W_W           = $clog2(MAX_WIDTH + 1);
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int CNT_W         = W_W + CFG_HEIGHT_W;
   localparam int CMP_W         = (W_W > CFG_WIDTH_W) ? W_W : CFG_WIDTH_W;
   localparam int SETTLE_CYCLES = 3;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);
   localparam int OCC_W         = $clog2(FIFO_DEPTH + 1);

   logic [CFG_WIDTH_W-1:0]  image_width_ff;
   logic [CFG_HEIGHT_W-1:0] image_height_ff;
   logic [SETTLE_W-1:0]     settle_ff;

   logic [CMP_W-1:0]        width_ext;
   logic [W_W-1:0]          w_eff_in, w_eff_ff;
   logic [CFG_HEIGHT_W-1:0] h_eff_in, h_eff_ff, hm1_ff;
   logic [COL_W-1:0]        wm1_ff;
   logic [CNT_W-1:0]        total_ff;

   logic [CNT_W-1:0]        push_cnt_ff, push_cnt_in, out_cnt_ff, out_cnt_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [CFG_HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;

   logic        accept, rsp_take, done, is_drain, push, produce, last_res, border;
   logic [2*PIX_W-1:0] gray_sum;
   pix_type     gray_in;
   gmf_tag_type push_tag;

   logic           win_valid;
   win_type        win;
   gmf_tag_type    win_tag;
   logic           med_valid;
   gmf_result_type med_res;
   gmf_result_type fifo_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         settle_ff       <= SETTLE_W'(SETTLE_CYCLES);
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   // Effective frame size, computed over the settle cycles.
   always_comb begin
      width_ext = CMP_W'(image_width_ff);
      if (image_width_ff == '0) begin
         w_eff_in = W_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff_in = W_W'(MAX_WIDTH);
      end else begin
         w_eff_in = W_W'(width_ext);
      end
      h_eff_in = (image_height_ff == '0) ? CFG_HEIGHT_W'(1) : image_height_ff;
   end

   always_ff @(posedge clock) begin
      w_eff_ff <= w_eff_in;
      h_eff_ff <= h_eff_in;
      wm1_ff   <= COL_W'(w_eff_ff - 1'b1);
      hm1_ff   <= h_eff_ff - 1'b1;
      total_ff <= CNT_W'(w_eff_ff) * CNT_W'(h_eff_ff);
   end

   // Item control.
   assign req_chan.ready = (settle_ff == '0) && (occ_ff < OCC_W'(FIFO_DEPTH));
   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign done     = (push_cnt_ff >= total_ff);
   assign is_drain = (req_chan.opcode == OP_DRAIN);
   // Drains are ignored until the frame's pixels are all in; after that every
   // item pushes an empty slot.
   assign push     = accept && (done || !is_drain);
   assign produce  = push && (push_cnt_ff > CNT_W'(w_eff_ff)) && (out_cnt_ff < total_ff);
   assign last_res = produce && (CNT_W'(out_cnt_ff + 1'b1) == total_ff);
   assign border   = (out_row_ff == '0) || (out_row_ff == hm1_ff) ||
                     (out_col_ff == '0) || (out_col_ff == wm1_ff);

   assign gray_sum = (2*PIX_W)'(req_chan.red)   * (2*PIX_W)'(GRAY_RED) +
                     (2*PIX_W)'(req_chan.green) * (2*PIX_W)'(GRAY_GREEN) +
                     (2*PIX_W)'(req_chan.blue)  * (2*PIX_W)'(GRAY_BLUE);
   assign gray_in  = done ? '0 : gray_sum[2*PIX_W-1:PIX_W];

   assign push_tag.result = produce;
   assign push_tag.last   = last_res;
   assign push_tag.border = border;

   always_comb begin
      push_cnt_in = push_cnt_ff;
      in_col_in   = in_col_ff;
      out_cnt_in  = out_cnt_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      occ_in      = occ_ff;
      if (push) begin
         push_cnt_in = push_cnt_ff + 1'b1;
         in_col_in   = (in_col_ff == wm1_ff) ? '0 : in_col_ff + 1'b1;
      end
      if (produce) begin
         out_cnt_in = out_cnt_ff + 1'b1;
         if (out_col_ff == wm1_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      if (last_res) begin
         push_cnt_in = '0;
         in_col_in   = '0;
         out_cnt_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
      end
      case ({produce, rsp_take})
         2'b10:   occ_in = occ_ff + 1'b1;
         2'b01:   occ_in = occ_ff - 1'b1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_cnt_ff <= '0;
         in_col_ff   <= '0;
         out_cnt_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         occ_ff      <= '0;
      end else begin
         push_cnt_ff <= push_cnt_in;
         in_col_ff   <= in_col_in;
         out_cnt_ff  <= out_cnt_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         occ_ff      <= occ_in;
      end
   end

   gmf_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_addr  (in_col_ff),
      .push_gray  (gray_in),
      .push_tag   (push_tag),
      .win_valid  (win_valid),
      .win        (win),
      .win_tag    (win_tag)
   );

   gmf_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_win    (win),
      .in_tag    (win_tag),
      .out_valid (med_valid),
      .out_res   (med_res)
   );

   gmf_out_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (med_valid),
      .wr_data  (med_res),
      .rd_valid (rsp_chan.valid),
      .rd_data  (fifo_res),
      .rd_ready (rsp_chan.ready)
   );

   assign rsp_chan.gray_value     = fifo_res.gray_value;
   assign rsp_chan.filtered_value = fifo_res.filtered_value;
   assign rsp_chan.last_of_frame  = fifo_res.last_of_frame;

endmodule

### test/gmf_median_monitor.sv
`timescale 1ns / 100ps

module gmf_median_monitor #(
   parameter int MAX_WIDTH = gmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   gmf_req_if                              pixel_tap,
   gmf_rsp_if                              result_tap,
   input  logic                            csr_we,
   input  logic [gmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gmf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              failures,
   output int                              pending
);
   import gmf_pkg::*;

   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   pix_type                 upper_row [MAX_WIDTH];
   pix_type                 middle_row [MAX_WIDTH];
   pix_type                 window [WIN_SIZE];
   int unsigned             push_row;
   int unsigned             push_col;
   int unsigned             results_made;
   gmf_result_type          expected_pixels [$];

   function automatic pix_type gray_level(input pix_type r, input pix_type g, input pix_type b);
      int unsigned acc;
      acc = GRAY_RED * r + GRAY_GREEN * g + GRAY_BLUE * b;
      return pix_type'(acc >> 8);
   endfunction

   // The median is the value with at most four entries below it and at least
   // five entries at or below it.
   function automatic pix_type median_of_nine(input pix_type v [WIN_SIZE]);
      int below;
      int not_above;
      for (int i = 0; i < WIN_SIZE; i++) begin
         below     = 0;
         not_above = 0;
         for (int j = 0; j < WIN_SIZE; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 4 && not_above >= 5) return v[i];
      end
      return v[4];
   endfunction

   task automatic push_item(input logic op, input pix_type r, input pix_type g,
                            input pix_type b);
      int unsigned    w;
      int unsigned    h;
      int unsigned    total;
      int unsigned    pos;
      int unsigned    col;
      int unsigned    out_row;
      int unsigned    out_col;
      pix_type        gray;
      gmf_result_type res;
      logic           done;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      total = w * h;
      if (results_made >= total) begin
         push_row     = 0;
         push_col     = 0;
         results_made = 0;
      end
      pos  = push_row * w + push_col;
      done = (pos >= total);
      // A drain inside an unfinished frame changes nothing.
      if (op == OP_DRAIN && !done) return;
      gray = done ? '0 : gray_level(r, g, b);

      col = (push_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : push_col;
      for (int k = 0; k < 3; k++) begin
         window[3*k]   = window[3*k+1];
         window[3*k+1] = window[3*k+2];
      end
      window[2]       = upper_row[col];
      window[5]       = middle_row[col];
      window[8]       = gray;
      upper_row[col]  = middle_row[col];
      middle_row[col] = gray;
      if (push_col + 1 >= w) begin
         push_col = 0;
         push_row++;
      end else begin
         push_col++;
      end

      // Results lag the pushes by one row plus one pixel.
      if (pos <= w || results_made >= total) return;
      out_row = results_made / w;
      out_col = results_made % w;
      res.gray_value = window[4];
      if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
         res.filtered_value = median_of_nine(window);
      end else begin
         res.filtered_value = window[4];
      end
      results_made++;
      res.last_of_frame = (results_made >= total);
      if (res.last_of_frame) begin
         push_row     = 0;
         push_col     = 0;
         results_made = 0;
      end
      expected_pixels.push_back(res);
   endtask

   always @(posedge clock) begin
      gmf_result_type want;
      gmf_result_type got;
      if (reset) begin
         width_reg    = RESET_IMAGE_WIDTH;
         height_reg   = RESET_IMAGE_HEIGHT;
         push_row     = 0;
         push_col     = 0;
         results_made = 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < WIN_SIZE; i++) window[i] = '0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_IMAGE_WIDTH) begin
               width_reg = csr_wdata[CFG_WIDTH_W-1:0];
            end else if (csr_index == REG_IMAGE_HEIGHT) begin
               height_reg = csr_wdata[CFG_HEIGHT_W-1:0];
            end
         end
         if (pixel_tap.valid && pixel_tap.ready) begin
            push_item(pixel_tap.opcode, pixel_tap.red, pixel_tap.green, pixel_tap.blue);
         end
         if (result_tap.valid && result_tap.ready) begin
            got.gray_value     = result_tap.gray_value;
            got.filtered_value = result_tap.filtered_value;
            got.last_of_frame  = result_tap.last_of_frame;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result gray %0d filtered %0d last %0b", $time,
                        got.gray_value, got.filtered_value, got.last_of_frame);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected gray %0d filtered %0d last %0b,",
                           $time, want.gray_value, want.filtered_value,
                           want.last_of_frame,
                           " actual gray %0d filtered %0d last %0b",
                           got.gray_value, got.filtered_value, got.last_of_frame);
                  failures++;
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import gmf_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int LIMIT_CYCLES  = 800000;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int CALM_ITEMS    = 250;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 100;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     failures;
   int                     pending;
   int unsigned            frame_w = 1;
   int unsigned            frame_h = 1;
   int unsigned            sent_items = 0;
   int unsigned            results_taken = 0;
   int unsigned            idle_pct = 0;
   int unsigned            result_idle_pct = 0;
   bit                     calm = 1'b0;
   bit                     hold_done = 1'b0;

   gmf_req_if pixel_chan ();
   gmf_rsp_if result_chan ();

   gray_median_3x3_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pixel_chan),
      .rsp_chan  (result_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gmf_median_monitor median_monitor (
      .clock      (clock),
      .reset      (reset),
      .pixel_tap  (pixel_chan),
      .result_tap (result_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && result_chan.valid && result_chan.ready) results_taken++;
   end

   // Result side: random stalls, and once a long hold so that the output queue
   // fills and the block has to stall its input.
   initial begin : result_sink
      result_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!hold_done && results_taken >= HOLD_AFTER) begin
            result_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(99) < result_idle_pct) begin
            result_chan.ready <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clock);
         end else begin
            result_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic offer_item(input logic op, input pix_type r, input pix_type g,
                             input pix_type b);
      if (!calm && $urandom_range(99) < idle_pct) begin
         pixel_chan.valid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      pixel_chan.valid  <= 1'b1;
      pixel_chan.opcode <= op;
      pixel_chan.red    <= r;
      pixel_chan.green  <= g;
      pixel_chan.blue   <= b;
      do @(posedge clock); while (!pixel_chan.ready);
      sent_items++;
   endtask

   // Waits until every expected result has arrived, then lets the pipeline
   // finish any ignored drains.
   task automatic settle_block();
      pixel_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_frame_size(input int unsigned w, input int unsigned h);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_we  <= 1'b0;
      frame_w = w;
      frame_h = h;
   endtask

   // One full frame of pixels, then one row plus one item of tail to flush it,
   // sometimes followed by one more drain. Tail pixels only act as drains.
   task automatic stream_frame();
      int unsigned mode;
      int unsigned level;
      int unsigned noise_pct;
      pix_type     r;
      pix_type     g;
      pix_type     b;
      mode      = $urandom_range(3);
      level     = $urandom_range(255);
      noise_pct = ($urandom_range(2) == 0) ? 0 : 4;
      for (int unsigned p = 0; p < frame_w * frame_h; p++) begin
         if ($urandom_range(99) < noise_pct) begin
            offer_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
         end
         case (mode)
            0: begin
               r = 8'($urandom);
               g = 8'($urandom);
               b = 8'($urandom);
            end
            1: begin
               r = $urandom_range(1) ? 8'hFF : 8'h00;
               g = $urandom_range(1) ? 8'hFF : 8'h00;
               b = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            2: begin
               r = pix_type'(level + p);
               g = pix_type'(level + 2 * p);
               b = pix_type'(level - p);
            end
            default: begin
               r = pix_type'(level) ^ pix_type'($urandom_range(15));
               g = pix_type'(level) ^ pix_type'($urandom_range(15));
               b = pix_type'(level) ^ pix_type'($urandom_range(15));
               // Salt and pepper, the case a median filter is meant for.
               if ($urandom_range(7) == 0) begin
                  r = $urandom_range(1) ? 8'hFF : 8'h00;
                  g = r;
                  b = r;
               end
            end
         endcase
         offer_item(OP_PIXEL, r, g, b);
      end
      for (int unsigned t = 0; t <= frame_w; t++) begin
         offer_item($urandom_range(1) ? OP_PIXEL : OP_DRAIN,
                    8'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(3) == 0) offer_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("%0t: run did not complete, %0d results still expected", $time, pending);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [23:0] corner_pixels [9];
      int unsigned random_end;
      int unsigned w;
      int unsigned h;
      corner_pixels = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'hFFFFFF,
                        24'h0000FF, 24'h808080, 24'h000000, 24'h010203};
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= REG_IMAGE_WIDTH;
      csr_wdata         <= '0;
      pixel_chan.valid  <= 1'b0;
      pixel_chan.opcode <= OP_PIXEL;
      pixel_chan.red    <= '0;
      pixel_chan.green  <= '0;
      pixel_chan.blue   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame with an interior pixel, built from extreme colors.
      load_frame_size(3, 3);
      offer_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) offer_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
         offer_item(OP_PIXEL, corner_pixels[i][23:16], corner_pixels[i][15:8],
                    corner_pixels[i][7:0]);
      end
      offer_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      offer_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
      offer_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
      offer_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      offer_item(OP_DRAIN, 8'h55, 8'hAA, 8'h55);

      // On a one-row frame the first tail drain yields nothing.
      load_frame_size(4, 1);
      offer_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      offer_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
      offer_item(OP_PIXEL, 8'hAA, 8'h55, 8'hAA);
      offer_item(OP_PIXEL, 8'h7F, 8'h80, 8'h01);
      for (int i = 0; i < 5; i++) offer_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

      // The long hold on the result side falls inside this frame, while its tail
      // items are still being offered.
      idle_pct        = 5;
      result_idle_pct = 10;
      load_frame_size(40, 3);
      stream_frame();

      random_end = sent_items + RANDOM_ITEMS;
      while (sent_items < random_end) begin
         calm = (sent_items + CALM_ITEMS >= random_end);
         case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         case ($urandom_range(2))
            0: result_idle_pct = 0;
            1: result_idle_pct = 8;
            default: result_idle_pct = 30;
         endcase
         // Frames of the same size often follow back to back.
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(5))
               0:       w = $urandom_range(2, 1);
               1, 2:    w = $urandom_range(8, 3);
               3, 4:    w = $urandom_range(20, 9);
               default: w = $urandom_range(64, 21);
            endcase
            h = (w > 20) ? $urandom_range(4, 1) : $urandom_range(10, 1);
            load_frame_size(w, h);
         end
         stream_frame();
      end

      settle_block();
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/gmf_pkg.sv
rtl/core/gmf_req_if.sv
rtl/core/gmf_rsp_if.sv
rtl/core/gmf_line_store.sv
rtl/core/gmf_median.sv
rtl/core/gmf_out_fifo.sv
rtl/core/gray_median_3x3_filter.sv
test/gmf_median_monitor.sv
test/tb_top.sv
